// File: rtl/utf8_lsi_pkg.sv
// Package for the UTF-8 line start index: constants, codes and shared types.
package utf8_lsi_pkg;

  localparam int unsigned MaxLines = 4096;
  localparam int unsigned IdxW     = $clog2(MaxLines);
  localparam int unsigned CntW     = IdxW + 1;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef enum logic {
    KIND_LINE   = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  localparam logic CfgStartChar = 1'b0;
  localparam logic CfgStartByte = 1'b1;

  // One table write request from the scanner.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [31:0]     char_ofs;
    logic [31:0]     byte_ofs;
  } tbl_wr_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [11:0] line_index;
    logic        found;
    logic [31:0] line_char_offset;
    logic [31:0] line_byte_offset;
    logic        table_full;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_WAIT   = 2'd2,
    ST_FINAL  = 2'd3
  } srch_state_e;

endpackage

// File: rtl/utf8_lsi_table.sv
// Line start table: two synchronous memories with one write and one read port.
module utf8_lsi_table (
  input  logic                    clk_i,
  input  utf8_lsi_pkg::tbl_wr_t   wr_i,
  input  logic [utf8_lsi_pkg::IdxW-1:0] rd_addr_i,
  output logic [31:0]             rd_char_o,
  output logic [31:0]             rd_byte_o
);
  import utf8_lsi_pkg::*;

  logic [31:0] char_mem [MaxLines];
  logic [31:0] byte_mem [MaxLines];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      char_mem[wr_i.addr] <= wr_i.char_ofs;
      byte_mem[wr_i.addr] <= wr_i.byte_ofs;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_char_o <= char_mem[rd_addr_i];
    rd_byte_o <= byte_mem[rd_addr_i];
  end

endmodule

// File: rtl/utf8_lsi_scan.sv
// Byte scanner: decodes UTF-8, tracks offsets and detects line breaks.
module utf8_lsi_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [1:0]            func_i,
  input  logic [7:0]            byte_i,
  input  logic [31:0]           start_char_i,
  input  logic [31:0]           start_byte_i,
  output utf8_lsi_pkg::tbl_wr_t wr_o,
  output logic                  res_valid_o,
  output utf8_lsi_pkg::res_t    res_o,
  output logic [utf8_lsi_pkg::CntW-1:0] line_count_o
);
  import utf8_lsi_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0] co_q, co_d, bo_q, bo_d;
  logic cr_q, cr_d, ovf_q, ovf_d;
  logic [1:0] left_q, left_d, stg_q, stg_d;
  logic [2:0] len_q, len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; co_q <= '0; bo_q <= '0; cr_q <= 1'b0; ovf_q <= 1'b0;
      left_q <= '0; stg_q <= '0; len_q <= '0;
    end else begin
      cnt_q <= cnt_d; co_q <= co_d; bo_q <= bo_d; cr_q <= cr_d; ovf_q <= ovf_d;
      left_q <= left_d; stg_q <= stg_d; len_q <= len_d;
    end
  end

  assign line_count_o = cnt_q;

  // Next state for one item; a break records the offsets at that point.
  always_comb begin
    logic rec, dec, sep;
    logic [31:0] rc, rb;
    cnt_d = cnt_q; co_d = co_q; bo_d = bo_q; cr_d = cr_q; ovf_d = ovf_q;
    left_d = left_q; stg_d = stg_q; len_d = len_q;
    rec = 1'b0; dec = 1'b0; sep = 1'b0;
    rc = co_q; rb = bo_q;
    if (step_i) begin
      case (func_i)
        FUNC_START: begin
          cnt_d = '0; ovf_d = 1'b0; cr_d = 1'b0; left_d = '0; len_d = '0; stg_d = '0;
          co_d = start_char_i; bo_d = start_byte_i;
          rec = 1'b1; rc = start_char_i; rb = start_byte_i;
        end
        FUNC_BYTE: begin
          if (cr_q) begin
            cr_d = 1'b0;
            rec = 1'b1;
            if (byte_i == 8'h0A) begin
              co_d = co_q + 32'd1; bo_d = bo_q + 32'd1;
              rc = co_d; rb = bo_d;
            end else begin
              dec = 1'b1;
            end
          end else begin
            dec = 1'b1;
          end
        end
        FUNC_END: begin
          if (len_q != 3'd0) begin
            co_d = co_q + 32'(len_q - {1'b0, left_q});
            len_d = '0; left_d = '0; stg_d = '0;
          end
          if (cr_q) begin
            cr_d = 1'b0; rec = 1'b1; rc = co_d;
          end
        end
        default: ;
      endcase
      // UTF-8 decode of one byte.
      if (dec) begin
        if (left_q != 2'd0 && byte_i[7:6] == 2'b10) begin
          bo_d = bo_q + 32'd1;
          left_d = left_q - 2'd1;
          if (stg_q == 2'd1 && byte_i == 8'h80) stg_d = 2'd2;
          else if (stg_q == 2'd2 && left_d == 2'd0 &&
                   (byte_i == 8'hA8 || byte_i == 8'hA9)) sep = 1'b1;
          else stg_d = 2'd0;
          if (left_d == 2'd0) begin
            co_d = co_q + ((len_q == 3'd4) ? 32'd2 : 32'd1);
            len_d = '0; stg_d = '0;
          end
        end else begin
          if (left_q != 2'd0) begin
            co_d = co_q + 32'(len_q - {1'b0, left_q});
            len_d = '0; left_d = '0; stg_d = '0;
          end
          bo_d = bo_q + 32'd1;
          if (byte_i < 8'h80) begin
            co_d = co_d + 32'd1;
            if (byte_i == 8'h0A) sep = 1'b1;
            if (byte_i == 8'h0D) cr_d = 1'b1;
          end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
            len_d = 3'd2; left_d = 2'd1; stg_d = 2'd0;
          end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
            len_d = 3'd3; left_d = 2'd2; stg_d = (byte_i == 8'hE2) ? 2'd1 : 2'd0;
          end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
            len_d = 3'd4; left_d = 2'd3; stg_d = 2'd0;
          end else begin
            co_d = co_d + 32'd1;
          end
        end
        if (sep) begin
          rec = 1'b1; rc = co_d; rb = bo_d;
        end
      end
    end
    // Table write and report for a recorded break.
    wr_o.we = 1'b0;
    wr_o.addr = cnt_d[IdxW-1:0];
    wr_o.char_ofs = rc;
    wr_o.byte_ofs = rb;
    res_o.kind = KIND_LINE;
    res_o.found = 1'b1;
    res_o.line_char_offset = rc;
    res_o.line_byte_offset = rb;
    res_o.line_index = '0;
    if (rec) begin
      if (cnt_d < CntW'(MaxLines)) begin
        wr_o.we = 1'b1;
        res_o.line_index = 12'(cnt_d);
        cnt_d = cnt_d + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    res_o.table_full = ovf_d;
    res_valid_o = rec;
  end

endmodule

// File: rtl/utf8_lsi_search.sv
// Binary search over the line start table, one probe per memory read.
module utf8_lsi_search (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           query_i,
  input  logic [utf8_lsi_pkg::CntW-1:0] count_i,
  input  logic                  ovf_i,
  input  logic [31:0]           rd_char_i,
  input  logic [31:0]           rd_byte_i,
  output logic [utf8_lsi_pkg::IdxW-1:0] rd_addr_o,
  output logic                  busy_o,
  output logic                  done_o,
  output utf8_lsi_pkg::res_t    res_o
);
  import utf8_lsi_pkg::*;

  srch_state_e st_q, st_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0] q_q, q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; lo_q <= '0; hi_q <= '0; mid_q <= '0;
    end else begin
      st_q <= st_d; lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    end
  end

  always_ff @(posedge clk_i) q_q <= q_d;

  // Next state: read mid, wait in ST_WAIT for the registered read data, narrow the range.
  always_comb begin
    logic [CntW-1:0] m;
    st_d = st_q; lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; q_d = q_q;
    m = '0;
    case (st_q)
      ST_IDLE: if (start_i) begin
        q_d = query_i; lo_d = '0; hi_d = count_i; st_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          m = lo_q + ((hi_q - lo_q) >> 1);
          mid_d = m; st_d = ST_WAIT;
        end else begin
          mid_d = lo_q - 1'b1; st_d = ST_FINAL;
        end
      end
      ST_WAIT: begin
        if (rd_char_i <= q_q) lo_d = mid_q + 1'b1;
        else hi_d = mid_q;
        st_d = ST_SEARCH;
      end
      ST_FINAL: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rd_addr_o = mid_d[IdxW-1:0];
    busy_o = (st_q != ST_IDLE);
    done_o = (st_q == ST_FINAL);
    res_o.kind = KIND_LOOKUP;
    res_o.table_full = ovf_i;
    if (lo_q == '0) begin
      res_o.found = 1'b0; res_o.line_index = '0;
      res_o.line_char_offset = '0; res_o.line_byte_offset = '0;
    end else begin
      res_o.found = 1'b1; res_o.line_index = 12'(mid_q);
      res_o.line_char_offset = rd_char_i; res_o.line_byte_offset = rd_byte_i;
    end
  end

endmodule

// File: rtl/utf8_line_start_index.sv
// Top level of the UTF-8 line start index.
// Source bytes, start and end items may stream back to back, one item per
// cycle while no lookup runs and the output is not stalled; a result is valid
// in the output register in the cycle after its item is taken. A lookup runs
// a binary search over the line start table, each probe a read and a wait
// state (the table memory's registered read), up to floor(log2(lines))+1
// probes, none for an empty table and at most 13. The input is held off from
// the lookup transfer until the search is idle, and the answer enters the
// output register from the final state. Table entries past the current line
// count are never used, so the table needs no clearing pass after reset.
module utf8_line_start_index (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // src_byte[7:0], query_offset[39:8]
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // line_index, found, line_char_offset,
                                      // line_byte_offset, table_full, zero pad
  output logic         m_axis_tuser,  // kind
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import utf8_lsi_pkg::*;

  logic [31:0] sc_q, sb_q;
  logic out_v_q;
  res_t out_q;
  logic acc, busy, done;
  tbl_wr_t wr;
  logic sv;
  res_t sres, qres;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] raddr;
  logic [31:0] rc, rb;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0; sb_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgStartChar) sc_q <= cfg_data_i;
      if (cfg_index_i == CfgStartByte) sb_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = !busy && (!out_v_q || m_axis_tready);
  assign acc = s_axis_tvalid && s_axis_tready;

  utf8_lsi_scan u_scan (
    .clk_i, .rst_ni, .step_i(acc), .func_i(s_axis_tuser), .byte_i(s_axis_tdata[7:0]),
    .start_char_i(sc_q), .start_byte_i(sb_q), .wr_o(wr), .res_valid_o(sv),
    .res_o(sres), .line_count_o(cnt)
  );

  utf8_lsi_table u_table (
    .clk_i, .wr_i(wr), .rd_addr_i(raddr), .rd_char_o(rc), .rd_byte_o(rb)
  );

  utf8_lsi_search u_search (
    .clk_i, .rst_ni, .start_i(acc && s_axis_tuser == FUNC_QUERY),
    .query_i(s_axis_tdata[39:8]), .count_i(cnt), .ovf_i(sres.table_full),
    .rd_char_i(rc), .rd_byte_i(rb), .rd_addr_o(raddr), .busy_o(busy),
    .done_o(done), .res_o(qres)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (sv || done) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done) out_q <= qres;
    else if (sv) out_q <= sres;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {2'd0, out_q.table_full, out_q.line_byte_offset,
                          out_q.line_char_offset, out_q.found, out_q.line_index};

endmodule

// File: rtl/utf8_lsi_checker.sv
// Port-level checker for the line start index, bound to the top level.
module utf8_lsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import utf8_lsi_pkg::*;

  a_start_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_START |=>
      m_axis_tvalid && m_axis_tuser == KIND_LINE && m_axis_tdata[11:0] == 12'd0)
    else $error("start item gave no line 0 result");

  a_query_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_QUERY |=> !s_axis_tready)
    else $error("input taken during a lookup");

  a_line_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_LINE |-> m_axis_tdata[12])
    else $error("line result without found");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind utf8_line_start_index utf8_lsi_checker u_chk (.*);
